// ===== rtl/crt_pkg.sv =====
package crt_pkg;

    localparam int          TAPS        = 4;
    localparam int          DIVISOR     = 250;
    localparam int          HALF_DIV    = 125;
    localparam logic [2:0]  LAST_SAMPLE = 3'd4;

    localparam logic [1:0]  POS_START = 2'd0;
    localparam logic [1:0]  POS_ONE   = 2'd1;
    localparam logic [1:0]  POS_TWO   = 2'd2;
    localparam logic [1:0]  POS_MANY  = 2'd3;

    localparam logic [2:0]  REG_SMOOTH_ADDR = 3'd0;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC_X,
        S_CALC_Y,
        S_LOAD
    } t_state;

    typedef enum logic [2:0] {
        U_IDLE,
        U_MAC,
        U_PREP,
        U_DIV,
        U_FIN
    } t_ustate;

    typedef struct packed {
        logic       start;
        logic [2:0] sample;
    } t_blend_ctl;

    localparam logic signed [8:0] WEIGHTS [0:4][0:3] = '{
        '{-9'sd16, 9'sd228, 9'sd42,  -9'sd4 },
        '{-9'sd18, 9'sd174, 9'sd106, -9'sd12},
        '{-9'sd12, 9'sd106, 9'sd174, -9'sd18},
        '{-9'sd4,  9'sd42,  9'sd228, -9'sd16},
        '{ 9'sd0,  9'sd0,   9'sd250,  9'sd0 }
    };

    function automatic logic signed [8:0] blend_weight(input logic [2:0] s,
                                                       input logic [1:0] k);
        logic signed [8:0] w;
        case (s)
            3'd0, 3'd1, 3'd2, 3'd3, 3'd4: w = WEIGHTS[s][k];
            default:                      w = 9'sd0;
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/catmull_rom_polyline_tessellator_top.sv =====
// Polyline tessellator: turns runs of 12.4 points into move/line-to path
// requests, optionally smoothed with uniform Catmull-Rom samples. A move or
// straight line-to point is accepted and lands in the output register at once;
// the next point can be taken in the cycle that request leaves. A smoothed
// span runs five samples through one shared multiply-accumulate and
// reciprocal divide-by-250 unit, x then y; a sample that saturates skips the
// divide, a stalled output holds a finished sample, and an end-of-run point
// that opens a span computes two spans. The point channel stays not ready
// while a span is being computed.
module catmull_rom_polyline_tessellator_top #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          i_point_valid,
    output logic                          o_point_ready,
    input  logic signed [COORD_WIDTH-1:0] i_point_x_in,
    input  logic signed [COORD_WIDTH-1:0] i_point_y_in,
    input  logic                          i_end_of_run,
    output logic                          o_path_valid,
    input  logic                          i_path_ready,
    output logic signed [COORD_WIDTH-1:0] o_path_x,
    output logic signed [COORD_WIDTH-1:0] o_path_y,
    output logic                          o_is_move,
    output logic                          o_last_of_burst
);
    import crt_pkg::*;

    t_state                        r_state, n_state;
    logic                          r_smooth;
    logic [1:0]                    r_pos;
    logic signed [COORD_WIDTH-1:0] r_hx [3];
    logic signed [COORD_WIDTH-1:0] r_hy [3];
    logic signed [COORD_WIDTH-1:0] r_px [TAPS];
    logic signed [COORD_WIDTH-1:0] r_py [TAPS];
    logic [2:0]                    r_samp;
    logic                          r_span2;
    logic signed [COORD_WIDTH-1:0] r_sx;
    logic signed [COORD_WIDTH-1:0] r_sy_hold;
    logic                          r_out_valid;
    logic signed [COORD_WIDTH-1:0] r_out_x;
    logic signed [COORD_WIDTH-1:0] r_out_y;
    logic                          r_out_move;
    logic                          r_out_last;

    logic                          accept;
    logic                          do_move;
    logic                          do_line;
    logic                          do_span;
    logic                          out_free;
    logic                          more;
    logic                          start;
    logic                          load_direct;
    logic                          load_calc;
    logic                          sel_y;
    logic                          cfg_write;
    t_blend_ctl                    blend_ctl;
    logic                          blend_done;
    logic signed [COORD_WIDTH-1:0] blend_res;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr == REG_SMOOTH_ADDR) ? {31'd0, r_smooth} : 32'd0;

    always_comb begin
        out_free      = !r_out_valid || i_path_ready;
        o_point_ready = (r_state == S_IDLE) && out_free;
        accept        = i_point_valid && o_point_ready;
        do_move       = (r_pos == POS_START);
        do_line       = !do_move && (!r_smooth || (r_pos == POS_ONE && i_end_of_run));
        do_span       = !do_move && r_smooth && (r_pos == POS_TWO || r_pos == POS_MANY);
        more          = (r_samp != LAST_SAMPLE) || r_span2;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   n_state = (accept && do_span) ? S_CALC_X : S_IDLE;
            S_CALC_X: n_state = blend_done ? S_CALC_Y : S_CALC_X;
            S_CALC_Y: n_state = blend_done ? S_LOAD : S_CALC_Y;
            S_LOAD:   n_state = out_free ? (more ? S_CALC_X : S_IDLE) : S_LOAD;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        start       = 1'b0;
        load_direct = 1'b0;
        load_calc   = 1'b0;
        sel_y       = 1'b0;
        case (r_state)
            S_IDLE: begin
                start       = accept && do_span;
                load_direct = accept && (do_move || do_line);
            end
            S_CALC_X: start = blend_done;
            S_CALC_Y: sel_y = 1'b1;
            S_LOAD: begin
                load_calc = out_free;
                start     = out_free && more;
            end
            default: begin
            end
        endcase
        blend_ctl = '{start: start, sample: r_samp};
    end

    crt_blend_unit #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_blend (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (blend_ctl),
        .i_c0     (sel_y ? r_py[0] : r_px[0]),
        .i_c1     (sel_y ? r_py[1] : r_px[1]),
        .i_c2     (sel_y ? r_py[2] : r_px[2]),
        .i_c3     (sel_y ? r_py[3] : r_px[3]),
        .o_done   (blend_done),
        .o_result (blend_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_smooth    <= 1'b0;
            r_pos       <= POS_START;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_write && paddr == REG_SMOOTH_ADDR) begin
                r_smooth <= pwdata[0];
            end
            if (accept) begin
                if (i_end_of_run) begin
                    r_pos <= POS_START;
                end else if (r_pos != POS_MANY) begin
                    r_pos <= r_pos + 2'd1;
                end
            end
            if (load_direct || load_calc) begin
                r_out_valid <= 1'b1;
            end else if (i_path_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_hx[2] <= r_hx[1];
            r_hy[2] <= r_hy[1];
            r_hx[1] <= r_hx[0];
            r_hy[1] <= r_hy[0];
            r_hx[0] <= i_point_x_in;
            r_hy[0] <= i_point_y_in;
        end
        if (accept && do_span) begin
            r_px[0] <= (r_pos == POS_TWO) ? r_hx[1] : r_hx[2];
            r_py[0] <= (r_pos == POS_TWO) ? r_hy[1] : r_hy[2];
            r_px[1] <= r_hx[1];
            r_py[1] <= r_hy[1];
            r_px[2] <= r_hx[0];
            r_py[2] <= r_hy[0];
            r_px[3] <= i_point_x_in;
            r_py[3] <= i_point_y_in;
            r_samp  <= '0;
            r_span2 <= i_end_of_run;
        end else if (load_calc && more) begin
            if (r_samp == LAST_SAMPLE) begin
                r_px[0] <= r_px[1];
                r_py[0] <= r_py[1];
                r_px[1] <= r_px[2];
                r_py[1] <= r_py[2];
                r_px[2] <= r_px[3];
                r_py[2] <= r_py[3];
                r_samp  <= '0;
                r_span2 <= 1'b0;
            end else begin
                r_samp <= r_samp + 3'd1;
            end
        end
        if (r_state == S_CALC_X && blend_done) begin
            r_sx <= blend_res;
        end
        if (load_direct) begin
            r_out_x    <= i_point_x_in;
            r_out_y    <= i_point_y_in;
            r_out_move <= do_move;
            r_out_last <= 1'b1;
        end else if (load_calc) begin
            r_out_x    <= r_sx;
            r_out_y    <= r_sy_hold;
            r_out_move <= 1'b0;
            r_out_last <= !more;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_CALC_Y && blend_done) begin
            r_sy_hold <= blend_res;
        end
    end

    assign o_path_valid    = r_out_valid;
    assign o_path_x        = r_out_x;
    assign o_path_y        = r_out_y;
    assign o_is_move       = r_out_move;
    assign o_last_of_burst = r_out_last;

endmodule

// ===== rtl/crt_blend_unit.sv =====
module crt_blend_unit #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  crt_pkg::t_blend_ctl           i_ctl,
    input  logic signed [COORD_WIDTH-1:0] i_c0,
    input  logic signed [COORD_WIDTH-1:0] i_c1,
    input  logic signed [COORD_WIDTH-1:0] i_c2,
    input  logic signed [COORD_WIDTH-1:0] i_c3,
    output logic                          o_done,
    output logic signed [COORD_WIDTH-1:0] o_result
);
    import crt_pkg::*;

    localparam int ACC_W = COORD_WIDTH + 10;
    localparam int QW    = COORD_WIDTH - 1;
    localparam int MW    = QW + 8;
    localparam int RW    = QW + 9;
    localparam int RSH   = QW + 16;
    localparam int RLO   = RW / 2;
    localparam int RHI   = RW - RLO;
    localparam int PW    = MW + RW;
    localparam logic [ACC_W-1:0] SAT_LIM = ACC_W'(DIVISOR) << QW;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << RSH) + 64'(DIVISOR - 1)) / 64'(DIVISOR);
    localparam logic [RW-1:0]  RECIP    = RECIP_FULL[RW-1:0];
    localparam logic [RLO-1:0] RECIP_LO = RECIP[RLO-1:0];
    localparam logic [RHI-1:0] RECIP_HI = RECIP[RW-1:RLO];

    t_ustate                   r_state, n_state;
    logic [1:0]                r_k;
    logic signed [ACC_W-1:0]   r_acc;
    logic [MW-1:0]             r_mag;
    logic [PW-1:0]             r_prod;
    logic                      r_hi;
    logic                      r_neg;
    logic                      r_sat;

    logic signed [COORD_WIDTH-1:0] coord;
    logic signed [8:0]             weight;
    logic signed [COORD_WIDTH+8:0] prod;
    logic signed [ACC_W-1:0]       mac_sum;
    logic [ACC_W-1:0]              acc_abs;
    logic [ACC_W-1:0]              mag;
    logic                          sat_hit;
    logic [RHI-1:0]                recip_part;
    logic [MW+RHI-1:0]             part;
    logic [COORD_WIDTH-1:0]        q_pos;

    always_comb begin
        case (r_k)
            2'd0:    coord = i_c0;
            2'd1:    coord = i_c1;
            2'd2:    coord = i_c2;
            default: coord = i_c3;
        endcase
        weight     = blend_weight(i_ctl.sample, r_k);
        prod       = (COORD_WIDTH+9)'(weight) * (COORD_WIDTH+9)'(coord);
        mac_sum    = r_acc + ACC_W'(prod);
        acc_abs    = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);
        mag        = acc_abs + ACC_W'(HALF_DIV);
        sat_hit    = (mag >= SAT_LIM);
        recip_part = r_hi ? RECIP_HI : RHI'(RECIP_LO);
        part       = (MW+RHI)'(r_mag) * (MW+RHI)'(recip_part);
        q_pos      = {1'b0, r_prod[RSH +: QW]};
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            U_IDLE, U_FIN: n_state = i_ctl.start ? U_MAC : U_IDLE;
            U_MAC:         n_state = (r_k == 2'(TAPS - 1)) ? U_PREP : U_MAC;
            U_PREP:        n_state = sat_hit ? U_FIN : U_DIV;
            U_DIV:         n_state = r_hi ? U_FIN : U_DIV;
            default:       n_state = U_IDLE;
        endcase
    end

    always_comb begin
        o_done = (r_state == U_FIN);
        if (r_sat) begin
            o_result = r_neg ? {1'b1, {QW{1'b0}}} : {1'b0, {QW{1'b1}}};
        end else begin
            o_result = r_neg ? -q_pos : q_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            U_IDLE, U_FIN: begin
                if (i_ctl.start) begin
                    r_acc <= '0;
                    r_k   <= '0;
                end
            end
            U_MAC: begin
                r_acc <= mac_sum;
                r_k   <= r_k + 2'd1;
            end
            U_PREP: begin
                r_neg <= r_acc[ACC_W-1];
                r_sat <= sat_hit;
                r_mag <= mag[MW-1:0];
                r_hi  <= 1'b0;
            end
            U_DIV: begin
                if (r_hi) begin
                    r_prod <= r_prod + (PW'(part) << RLO);
                end else begin
                    r_prod <= PW'(part);
                end
                r_hi <= 1'b1;
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== rtl/crt_checker.sv =====
module crt_checker #(
    parameter int COORD_WIDTH = 16
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_point_ready,
    input logic                          o_path_valid,
    input logic                          i_path_ready,
    input logic signed [COORD_WIDTH-1:0] o_path_x,
    input logic signed [COORD_WIDTH-1:0] o_path_y,
    input logic                          o_is_move,
    input logic                          o_last_of_burst
);

    a_path_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_path_valid && !i_path_ready |=>
            o_path_valid && $stable(o_path_x) && $stable(o_path_y)
            && $stable(o_is_move) && $stable(o_last_of_burst))
        else $error("stalled path request changed");

    a_ready_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_point_ready && o_path_valid |-> i_path_ready)
        else $error("point ready while output register is blocked");

    a_move_ends_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_path_valid && o_is_move |-> o_last_of_burst)
        else $error("move request not last of its burst");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_path_valid)
        else $error("path valid right after reset");

endmodule

bind catmull_rom_polyline_tessellator_top crt_checker #(
    .COORD_WIDTH (COORD_WIDTH)
) u_crt_checker (.*);

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import crt_pkg::*;

    localparam int CW             = 16;
    localparam int SAMPLE_CYCLES  = 17;
    localparam int SETTLE_CYCLES  = 2 * 5 * SAMPLE_CYCLES + 20;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SHOWN_ERRORS   = 10;

    typedef struct {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic                 is_move;
        logic                 last_of_burst;
    } t_path_cmd;

    class path_scoreboard;
        logic signed [CW-1:0] hist_x [3];
        logic signed [CW-1:0] hist_y [3];
        logic [1:0]           run_pos;
        bit                   smooth;
        t_path_cmd            expected_cmds [$];
        int                   errors;

        function new();
            for (int i = 0; i < 3; i++) begin
                hist_x[i] = '0;
                hist_y[i] = '0;
            end
            run_pos = POS_START;
            smooth  = 1'b0;
            errors  = 0;
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= SHOWN_ERRORS) begin
                $display("%0t: mismatch: %s", $time, msg);
            end
        endfunction

        function logic signed [CW-1:0] spline_sample(int s, longint a, longint b,
                                                     longint c, longint d);
            longint w0 = -25 * s + 10 * s * s - s * s * s;
            longint w1 = 250 - 25 * s * s + 3 * s * s * s;
            longint w2 = 25 * s + 20 * s * s - 3 * s * s * s;
            longint w3 = -5 * s * s + s * s * s;
            longint hi = (longint'(1) <<< (CW - 1)) - 1;
            longint lo = -hi - 1;
            longint acc;
            longint q;
            acc = w0 * a + w1 * b + w2 * c + w3 * d;
            if (acc >= 0) begin
                q = (acc + 125) / 250;
            end else begin
                q = -((-acc + 125) / 250);
            end
            if (q > hi) q = hi;
            if (q < lo) q = lo;
            return q[CW-1:0];
        endfunction

        function void push_cmd(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                               logic mv);
            t_path_cmd c;
            c.x             = x;
            c.y             = y;
            c.is_move       = mv;
            c.last_of_burst = 1'b0;
            expected_cmds.push_back(c);
        endfunction

        function void push_span(longint x0, longint y0, longint x1, longint y1,
                                longint x2, longint y2, longint x3, longint y3);
            for (int s = 1; s <= 5; s++) begin
                push_cmd(spline_sample(s, x0, x1, x2, x3),
                         spline_sample(s, y0, y1, y2, y3), 1'b0);
            end
        endfunction

        function void take_point(logic signed [CW-1:0] px, logic signed [CW-1:0] py,
                                 logic eor);
            int                   before_cnt;
            logic signed [CW-1:0] ax;
            logic signed [CW-1:0] ay;
            before_cnt = expected_cmds.size();
            if (run_pos == POS_START) begin
                push_cmd(px, py, 1'b1);
            end else if (!smooth || (run_pos == POS_ONE && eor)) begin
                push_cmd(px, py, 1'b0);
            end else if (run_pos != POS_ONE) begin
                ax = (run_pos == POS_TWO) ? hist_x[1] : hist_x[2];
                ay = (run_pos == POS_TWO) ? hist_y[1] : hist_y[2];
                push_span(ax, ay, hist_x[1], hist_y[1], hist_x[0], hist_y[0], px, py);
                if (eor) begin
                    push_span(hist_x[1], hist_y[1], hist_x[0], hist_y[0],
                              px, py, px, py);
                end
            end
            hist_x[2] = hist_x[1];
            hist_y[2] = hist_y[1];
            hist_x[1] = hist_x[0];
            hist_y[1] = hist_y[0];
            hist_x[0] = px;
            hist_y[0] = py;
            if (eor) begin
                run_pos = POS_START;
            end else if (run_pos != POS_MANY) begin
                run_pos = run_pos + 2'd1;
            end
            if (expected_cmds.size() > before_cnt) begin
                expected_cmds[expected_cmds.size() - 1].last_of_burst = 1'b1;
            end
        endfunction

        function void check_path(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                                 logic mv, logic lb);
            t_path_cmd want;
            if (expected_cmds.size() == 0) begin
                report($sformatf("unexpected path request x=%0d y=%0d move=%0b last=%0b",
                                 x, y, mv, lb));
                return;
            end
            want = expected_cmds.pop_front();
            if (x !== want.x) begin
                report($sformatf("path_x expected %0d got %0d", want.x, x));
            end
            if (y !== want.y) begin
                report($sformatf("path_y expected %0d got %0d", want.y, y));
            end
            if (mv !== want.is_move) begin
                report($sformatf("is_move expected %0b got %0b", want.is_move, mv));
            end
            if (lb !== want.last_of_burst) begin
                report($sformatf("last_of_burst expected %0b got %0b",
                                 want.last_of_burst, lb));
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [2:0]           paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 i_point_valid;
    logic                 o_point_ready;
    logic signed [CW-1:0] i_point_x_in;
    logic signed [CW-1:0] i_point_y_in;
    logic                 i_end_of_run;
    logic                 o_path_valid;
    logic                 i_path_ready;
    logic signed [CW-1:0] o_path_x;
    logic signed [CW-1:0] o_path_y;
    logic                 o_is_move;
    logic                 o_last_of_burst;

    path_scoreboard sb = new();
    int             src_idle_pct;
    int             sink_stall_pct;
    int             stall_cycles;

    catmull_rom_polyline_tessellator_top #(
        .COORD_WIDTH(CW)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_point_valid  (i_point_valid),
        .o_point_ready  (o_point_ready),
        .i_point_x_in   (i_point_x_in),
        .i_point_y_in   (i_point_y_in),
        .i_end_of_run   (i_end_of_run),
        .o_path_valid   (o_path_valid),
        .i_path_ready   (i_path_ready),
        .o_path_x       (o_path_x),
        .o_path_y       (o_path_y),
        .o_is_move      (o_is_move),
        .o_last_of_burst(o_last_of_burst)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_path_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_path_valid && i_path_ready) begin
                sb.check_path(o_path_x, o_path_y, o_is_move, o_last_of_burst);
            end
            if (i_point_valid && o_point_ready) begin
                sb.take_point(i_point_x_in, i_point_y_in, i_end_of_run);
            end
            if ((o_path_valid && i_path_ready) || (i_point_valid && o_point_ready) ||
                (!i_point_valid && sb.expected_cmds.size() == 0)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles = stall_cycles + 1;
            end
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    task automatic send_point(input logic [CW-1:0] x, input logic [CW-1:0] y,
                              input logic eor);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_point_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_point_valid <= 1'b1;
        i_point_x_in  <= x;
        i_point_y_in  <= y;
        i_end_of_run  <= eor;
        do @(posedge i_clk); while (!(i_point_valid && o_point_ready));
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_point_valid <= 1'b0;
        while (sb.expected_cmds.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic reg_read(input logic [2:0] addr, output logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        data = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_mode(input bit on);
        logic [31:0] got;
        drain();
        reg_write(REG_SMOOTH_ADDR, {31'b0, on});
        sb.smooth = on;
        reg_read(REG_SMOOTH_ADDR, got);
        if (got[0] !== on) begin
            sb.report($sformatf("smooth_enable readback expected %0b got %0b", on, got[0]));
        end
    endtask

    function automatic logic [CW-1:0] pick_coord(logic [CW-1:0] prev);
        case ($urandom_range(0, 5))
            0:       return CW'($urandom);
            1:       return 16'h7FFF - CW'($urandom_range(0, 3));
            2:       return 16'h8000 + CW'($urandom_range(0, 3));
            default: return prev + CW'($urandom_range(0, 511)) - CW'(256);
        endcase
    endfunction

    task automatic send_run(input int len);
        logic [CW-1:0] cx;
        logic [CW-1:0] cy;
        cx = CW'($urandom);
        cy = CW'($urandom);
        for (int i = 0; i < len; i++) begin
            send_point(cx, cy, i == len - 1);
            cx = pick_coord(cx);
            cy = pick_coord(cy);
        end
    endtask

    task automatic random_phase(input int idle_pct, input int stall_pct, input bit on,
                                input int n_items);
        int sent;
        int len;
        set_mode(on);
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        sent = 0;
        while (sent < n_items) begin
            case ($urandom_range(0, 9))
                0:       len = 1;
                1:       len = 2;
                default: len = $urandom_range(3, 8);
            endcase
            send_run(len);
            sent += len;
        end
    endtask

    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        i_point_valid  = 1'b0;
        i_point_x_in   = '0;
        i_point_y_in   = '0;
        i_end_of_run   = 1'b0;
        i_path_ready   = 1'b0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        stall_cycles   = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_mode(1'b0);
        send_point(16'sd0, 16'sd0, 1'b1);
        send_point(16'sh7FFF, 16'sh8000, 1'b0);
        send_point(16'sh8000, 16'sh7FFF, 1'b1);
        send_point(16'sd16, 16'sd32, 1'b0);
        send_point(-16'sd48, 16'sd80, 1'b0);
        send_point(16'sd5, -16'sd5, 1'b1);

        set_mode(1'b1);
        send_point(-16'sd1, 16'sd1, 1'b1);
        send_point(16'sd100, 16'sd200, 1'b0);
        send_point(-16'sd300, 16'sd400, 1'b1);
        send_point(16'sh7FFF, 16'sh7FFF, 1'b0);
        send_point(16'sh8000, 16'sh8000, 1'b0);
        send_point(16'sh7FFF, 16'sh7FFF, 1'b1);
        send_point(16'sd0, 16'sd0, 1'b0);
        send_point(16'sd160, 16'sd16, 1'b0);
        send_point(16'sd320, -16'sd16, 1'b0);
        send_point(16'sd480, 16'sd0, 1'b1);

        // drop to straight mode while the second point is held
        send_point(16'sd10, 16'sd10, 1'b0);
        send_point(16'sd20, 16'sd30, 1'b0);
        set_mode(1'b0);
        send_point(16'sd40, -16'sd20, 1'b1);

        // switch to smooth mode late in a straight run
        send_point(16'sd1, 16'sd2, 1'b0);
        send_point(16'sd3, 16'sd4, 1'b0);
        send_point(16'sd5, 16'sd6, 1'b0);
        set_mode(1'b1);
        send_point(16'sd7, 16'sd8, 1'b1);

        random_phase(0, 0, 1'b1, 18);
        random_phase(72, 0, 1'b1, 18);
        random_phase(0, 72, 1'b0, 18);
        random_phase(19, 19, 1'b1, 18);

        drain();
        if (sb.errors == 0 && sb.expected_cmds.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
